### rtl/core/lzw_variable_width_encoder_unit_macros.svh
// Assertion macros for the LZW variable width encoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define LZWE_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must be followed by another in the next cycle
`define LZWE_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/lzwe_pkg.sv
// Shared types and constants for the LZW variable width encoder.
// No dependencies; imported by every module of the block.
package lzwe_pkg;

    localparam int DICT_SLOTS = 6144;
    localparam int ADDR_W     = 13;
    localparam int CODE_W     = 12;
    localparam int ACC_W      = 19;
    localparam int Q_PTR_W    = 2;
    localparam int Q_DEPTH    = 4;

    localparam logic [3:0]  MAX_WIDTH  = 4'd12;
    localparam logic [3:0]  BASE_WIDTH = 4'd8;
    localparam logic [12:0] BASE_CODE  = 13'd256;

    typedef enum logic
    {
        KIND_DATA  = 1'b0,
        KIND_FLUSH = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
        logic       err;
    } res_t;

    typedef struct packed
    {
        logic              valid;
        logic [CODE_W-1:0] prefix;
        logic [7:0]        data;
        logic [CODE_W-1:0] code;
    } dict_entry_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } eng_state_t;

    typedef struct packed
    {
        logic clearing;
        logic res_push;
    } eng_status_t;

endpackage

### rtl/core/lzw_variable_width_encoder_unit.sv
// Top level of the LZW variable width encoder.
// Depends on lzwe_pkg, lzwe_front, lzwe_engine, lzwe_out_q and the macros header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | push / full          | op, data_byte
//  result   | pop / empty          | out_byte, last, empty_error
//  config   | cfg_valid / cfg_ready| cfg_data (max_code_width)
//
// A data byte is taken in the idle state and then probes the hashed dictionary,
// one slot per probe; a miss then emits its result bytes, and a flush its final
// bytes and pad byte, both stalling while the result queue is full. After reset, after each flush of data and
// after each dictionary restart the engine sweeps the 6144-slot dictionary, one
// slot a cycle, and full stays high meanwhile. Four-entry queues on both sides
// let input and results stall independently.
`include "lzw_variable_width_encoder_unit_macros.svh"

module lzw_variable_width_encoder_unit
    import lzwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       empty_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    logic        [3:0] max_width_reg;
    logic              q_full;
    logic              avail;
    item_t             head;
    logic              eng_pop;
    logic              res_full;
    res_t              res_data;
    res_t              res_head;
    eng_status_t       status;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= MAX_WIDTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_width_reg <= cfg_data;
        end
    end

    // Hold off requests during a dictionary sweep
    assign full = q_full || status.clearing;

    lzwe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !status.clearing),
        .op        (op),
        .data_byte (data_byte),
        .q_full    (q_full),
        .avail     (avail),
        .head      (head),
        .pop       (eng_pop)
    );

    lzwe_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_width (max_width_reg),
        .avail     (avail),
        .head      (head),
        .pop       (eng_pop),
        .res_full  (res_full),
        .res_data  (res_data),
        .status    (status)
    );

    lzwe_out_q u_out_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (status.res_push),
        .wr_data (res_data),
        .q_full  (res_full),
        .q_empty (empty),
        .head    (res_head),
        .rd      (pop)
    );

    assign out_byte    = res_head.data;
    assign last        = res_head.last;
    assign empty_error = res_head.err;

    // An error result always closes its run
    `LZWE_CHECK(a_err_is_last, empty || !empty_error || last, "error result without last")
    // Nothing is taken from the front queue during a sweep
    `LZWE_CHECK(a_no_pop_clear, !(status.clearing && eng_pop), "request taken during sweep")
    // A held result byte stays in place while the result queue is full
    `LZWE_IMPLY(a_push_hold, status.res_push && res_full, status.res_push, "result dropped")

endmodule

### rtl/core/lzwe_front.sv
// Front end: request queue that accepts and classifies input items.
// Depends on lzwe_pkg.
module lzwe_front
    import lzwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       q_full,
    output logic       avail,
    output item_t      head,
    input  logic       pop
);

    item_t              slot_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg;
    logic [Q_PTR_W-1:0] wr_next;
    logic [Q_PTR_W-1:0] rd_reg;
    logic [Q_PTR_W-1:0] rd_next;
    logic [Q_PTR_W:0]   cnt_reg;
    logic [Q_PTR_W:0]   cnt_next;
    logic               do_push;
    logic               do_pop;
    item_t              in_item;

    // Classify the incoming request
    always_comb
    begin
        in_item.kind = op ? KIND_FLUSH : KIND_DATA;
        in_item.data = data_byte;
    end

    assign q_full  = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign head    = slot_mem[rd_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && avail;

    // Advance pointers
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/lzwe_out_q.sv
// Result queue between the encoder engine and the output ports.
// Depends on lzwe_pkg.
module lzwe_out_q
    import lzwe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  res_t wr_data,
    output logic q_full,
    output logic q_empty,
    output res_t head,
    input  logic rd
);

    res_t               slot_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg;
    logic [Q_PTR_W-1:0] wr_next;
    logic [Q_PTR_W-1:0] rd_reg;
    logic [Q_PTR_W-1:0] rd_next;
    logic [Q_PTR_W:0]   cnt_reg;
    logic [Q_PTR_W:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign head    = slot_mem[rd_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;

    // Advance pointers
    always_comb
    begin
        wr_next  = do_wr ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_rd ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_PTR_W+1)'(do_wr) - (Q_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_mem[wr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/lzwe_engine.sv
// Back end: dictionary lookup with linear probing, insert, code packing.
// Depends on lzwe_pkg; holds the dictionary memory.
module lzwe_engine
    import lzwe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  max_width,
    input  logic        avail,
    input  item_t       head,
    output logic        pop,
    input  logic        res_full,
    output res_t        res_data,
    output eng_status_t status
);

    dict_entry_t       dict_mem [DICT_SLOTS];
    dict_entry_t       rd_q;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    dict_entry_t       mem_wd;

    eng_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic              pvalid_reg, pvalid_next;
    logic [12:0]       ncode_reg, ncode_next;
    logic [3:0]        width_reg, width_next;
    logic [7:0]        byte_reg, byte_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [4:0]        tot_reg, tot_next;
    logic              pad_reg, pad_next;
    logic              err_reg, err_next;
    logic              restart_reg, restart_next;

    logic [6:0]        part7;
    logic [CODE_W-1:0] code_mask;
    logic [ACC_W-1:0]  acc_emit;
    logic [4:0]        tot_emit;
    logic [ADDR_W-1:0] hash_addr;
    logic [ADDR_W-1:0] addr_inc;
    logic [ACC_W-1:0]  acc_shift;
    logic [14:0]       pad_wide;
    logic [3:0]        limit;
    logic [4:0]        width_grown;
    logic              ncode_pow2;
    logic              hit;
    logic              emit_more;
    logic              emit_done;

    // Map a (prefix, byte) key onto a dictionary slot
    function automatic logic [ADDR_W-1:0] slot_of(logic [CODE_W-1:0] p, logic [7:0] b);
        logic [ADDR_W-1:0] h;
        h = {p, 1'b0} ^ {b, 5'b0};
        return (h >= ADDR_W'(DICT_SLOTS)) ? h - ADDR_W'(DICT_SLOTS) : h;
    endfunction

    // Packer and hashing terms
    always_comb
    begin
        part7       = acc_reg[6:0] & ~(7'h7F << tot_reg[2:0]);
        code_mask   = ~({CODE_W{1'b1}} << width_reg);
        acc_emit    = (ACC_W'(part7) << width_reg) | ACC_W'(prefix_reg & code_mask);
        tot_emit    = tot_reg + 5'(width_reg);
        hash_addr   = slot_of(prefix_reg, head.data);
        addr_inc    = (addr_reg == ADDR_W'(DICT_SLOTS - 1)) ? '0 : addr_reg + 1'b1;
        acc_shift   = acc_reg >> (tot_reg - 5'd8);
        pad_wide    = {8'd0, part7} << (4'd8 - {1'b0, tot_reg[2:0]});
        limit       = (max_width > MAX_WIDTH) ? MAX_WIDTH : max_width;
        ncode_pow2  = (ncode_reg != '0) && ((ncode_reg & (ncode_reg - 1'b1)) == '0);
        width_grown = {1'b0, width_reg} + 5'(ncode_pow2);
        hit         = rd_q.valid && (rd_q.prefix == prefix_reg) && (rd_q.data == byte_reg);
        emit_more   = (tot_reg >= 5'd8) || pad_reg;
        emit_done   = !res_full && ((tot_reg < 5'd16) && !pad_reg ||
                      (tot_reg < 5'd8)) || !emit_more;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(DICT_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (avail && (head.kind == KIND_FLUSH))
                begin
                    state_next = ST_EMIT;
                end
                else if (avail && pvalid_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rd_q.valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = restart_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        clr_next     = clr_reg;
        prefix_next  = prefix_reg;
        pvalid_next  = pvalid_reg;
        ncode_next   = ncode_reg;
        width_next   = width_reg;
        byte_next    = byte_reg;
        addr_next    = addr_reg;
        acc_next     = acc_reg;
        tot_next     = tot_reg;
        pad_next     = pad_reg;
        err_next     = err_reg;
        restart_next = restart_reg;
        pop          = 1'b0;
        rd_addr      = hash_addr;
        mem_we       = 1'b0;
        mem_wa       = addr_reg;
        mem_wd       = '0;
        status.clearing = (state_reg == ST_CLEAR);
        status.res_push = 1'b0;
        res_data     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the dictionary, one slot a cycle
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = (clr_reg == ADDR_W'(DICT_SLOTS - 1)) ? '0 : clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                pop = avail;
                if (avail && (head.kind == KIND_FLUSH))
                begin
                    // Final code then pad; no data means an error result
                    acc_next     = pvalid_reg ? acc_emit : '0;
                    tot_next     = pvalid_reg ? tot_emit : '0;
                    err_next     = !pvalid_reg;
                    restart_next = pvalid_reg;
                    pad_next     = 1'b1;
                    pvalid_next  = 1'b0;
                    prefix_next  = '0;
                    width_next   = BASE_WIDTH;
                    ncode_next   = BASE_CODE;
                end
                else if (avail && !pvalid_reg)
                begin
                    prefix_next = CODE_W'(head.data);
                    pvalid_next = 1'b1;
                end
                else if (avail)
                begin
                    byte_next = head.data;
                    addr_next = hash_addr;
                end
            end
            ST_CHECK:
            begin
                rd_addr = addr_inc;
                if (hit)
                begin
                    prefix_next = rd_q.code;
                end
                else if (rd_q.valid)
                begin
                    addr_next = addr_inc;
                end
                else
                begin
                    // Miss: insert, emit prefix, grow width, maybe restart
                    mem_we        = 1'b1;
                    mem_wd.valid  = 1'b1;
                    mem_wd.prefix = prefix_reg;
                    mem_wd.data   = byte_reg;
                    mem_wd.code   = ncode_reg[CODE_W-1:0];
                    acc_next      = acc_emit;
                    tot_next      = tot_emit;
                    pad_next      = 1'b0;
                    err_next      = 1'b0;
                    prefix_next   = CODE_W'(byte_reg);
                    if (width_grown > {1'b0, limit})
                    begin
                        restart_next = 1'b1;
                        width_next   = BASE_WIDTH;
                        ncode_next   = BASE_CODE;
                    end
                    else
                    begin
                        restart_next = 1'b0;
                        width_next   = width_grown[3:0];
                        ncode_next   = ncode_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                // Drain whole bytes, then the pad byte on flush
                if (tot_reg >= 5'd8)
                begin
                    status.res_push = 1'b1;
                    res_data.data   = acc_shift[7:0];
                    res_data.last   = !pad_reg && (tot_reg < 5'd16);
                    res_data.err    = 1'b0;
                    if (!res_full)
                    begin
                        tot_next = tot_reg - 5'd8;
                    end
                end
                else if (pad_reg)
                begin
                    status.res_push = 1'b1;
                    res_data.data   = pad_wide[7:0];
                    res_data.last   = 1'b1;
                    res_data.err    = err_reg;
                    if (!res_full)
                    begin
                        tot_next = '0;
                        pad_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            prefix_reg  <= '0;
            pvalid_reg  <= 1'b0;
            ncode_reg   <= BASE_CODE;
            width_reg   <= BASE_WIDTH;
            acc_reg     <= '0;
            tot_reg     <= '0;
            pad_reg     <= 1'b0;
            err_reg     <= 1'b0;
            restart_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            prefix_reg  <= prefix_next;
            pvalid_reg  <= pvalid_next;
            ncode_reg   <= ncode_next;
            width_reg   <= width_next;
            acc_reg     <= acc_next;
            tot_reg     <= tot_next;
            pad_reg     <= pad_next;
            err_reg     <= err_next;
            restart_reg <= restart_next;
        end
    end

    // Hold the probe key
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        addr_reg <= addr_next;
    end

    // Dictionary memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_wa] <= mem_wd;
        end
        rd_q <= dict_mem[rd_addr];
    end

endmodule
